// ===== hw/rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search core.
package stbs_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned ValW       = 32;

  localparam logic OpLookup = 1'b0;
  localparam logic OpWrite  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP,
    ST_RESP
  } stbs_state_e;

  typedef struct packed {
    logic init;
    logic clear;
    logic take_hit;
    logic step;
    logic use_nxt;
    logic rd_en;
    logic wr_en;
  } stbs_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_gt1;
    logic hit;
    logic nxt_zero;
  } stbs_status_t;

endpackage

// ===== hw/rtl/sorted_table_binary_search_core.sv =====
// Top level: binary search over a software-loaded sorted table of 32-bit values.
// Write: acknowledge strobe in the cycle after acceptance; the next transaction is taken once idle again.
// Lookup: result strobe after p probes (at most 9 for 256 entries),
// one table read per cycle; a new lookup is accepted only after the strobe, once idle again.
// One transaction at a time: busy is high from acceptance until the strobe; no output stall.
// Reset clears case_count and control state; the table contents are undefined until written.
module sorted_table_binary_search_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation_i,
  input  logic [stbs_pkg::IdxW-1:0] entry_index_i,
  input  logic [stbs_pkg::ValW-1:0] case_value_i,
  input  logic                      cfg_we_i,
  input  logic [stbs_pkg::CntW-1:0] cfg_wdata_i,
  output logic                      done_o,
  output logic                      found_o,
  output logic [stbs_pkg::IdxW-1:0] match_index_o
);
  import stbs_pkg::*;

  stbs_cmd_t    cmd;
  stbs_status_t status;

  stbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .operation_i(operation_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy),
    .done_o     (done_o)
  );

  stbs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .entry_index_i(entry_index_i),
    .case_value_i (case_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .found_o      (found_o),
    .match_index_o(match_index_o)
  );

endmodule

// ===== hw/rtl/stbs_ram.sv =====
// Generic single write port, single registered read port RAM.
module stbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/stbs_dp.sv =====
// Datapath: value table, search window, key and result registers.
module stbs_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [stbs_pkg::CntW-1:0] cfg_wdata_i,
  input  logic [stbs_pkg::IdxW-1:0] entry_index_i,
  input  logic [stbs_pkg::ValW-1:0] case_value_i,
  input  stbs_pkg::stbs_cmd_t       cmd_i,
  output stbs_pkg::stbs_status_t    status_o,
  output logic                      found_o,
  output logic [stbs_pkg::IdxW-1:0] match_index_o
);
  import stbs_pkg::*;

  localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

  logic [CntW-1:0] case_count_q;
  logic [CntW-1:0] start_q, start_d;
  logic [CntW-1:0] n_q, n_d;
  logic [ValW-1:0] key_q;
  logic            found_q, found_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [CntW-1:0] sat_count;
  logic [CntW-1:0] mid;
  logic [CntW-1:0] nxt_start, nxt_n, nxt_mid;
  logic [IdxW-1:0] cur_addr, nxt_addr, rd_addr;
  logic [ValW-1:0] probe;
  logic            key_lt;

  stbs_ram #(
    .Width(ValW),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(entry_index_i),
    .wdata_i(case_value_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(probe)
  );

  assign sat_count = (case_count_q > DepthCnt) ? DepthCnt : case_count_q;

  assign mid      = start_q + (n_q >> 1);
  assign cur_addr = (n_q > CntW'(1)) ? mid[IdxW-1:0] : start_q[IdxW-1:0];

  assign key_lt    = key_q < probe;
  assign nxt_start = key_lt ? start_q : (mid + CntW'(1));
  assign nxt_n     = key_lt ? (n_q >> 1) : (n_q - (n_q >> 1) - CntW'(1));
  assign nxt_mid   = nxt_start + (nxt_n >> 1);
  assign nxt_addr  = (nxt_n > CntW'(1)) ? nxt_mid[IdxW-1:0] : nxt_start[IdxW-1:0];

  assign rd_addr = cmd_i.use_nxt ? nxt_addr : cur_addr;

  assign status_o.n_zero   = (n_q == '0);
  assign status_o.n_gt1    = (n_q > CntW'(1));
  assign status_o.hit      = (probe == key_q);
  assign status_o.nxt_zero = (nxt_n == '0);

  always_comb begin
    start_d = start_q;
    n_d     = n_q;
    found_d = found_q;
    idx_d   = idx_q;
    if (cmd_i.init) begin
      start_d = '0;
      n_d     = sat_count;
    end
    if (cmd_i.step) begin
      start_d = nxt_start;
      n_d     = nxt_n;
    end
    if (cmd_i.clear) begin
      found_d = 1'b0;
      idx_d   = '0;
    end
    if (cmd_i.take_hit) begin
      found_d = 1'b1;
      idx_d   = cur_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_count_q <= '0;
      start_q      <= '0;
      n_q          <= '0;
      found_q      <= 1'b0;
      idx_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case_count_q <= cfg_wdata_i;
      end
      start_q <= start_d;
      n_q     <= n_d;
      found_q <= found_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      key_q <= case_value_i;
    end
  end

  assign found_o       = found_q;
  assign match_index_o = idx_q;

endmodule

// ===== hw/rtl/stbs_ctrl.sv =====
// Controller: sequences table writes and the probes of a lookup.
module stbs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   operation_i,
  input  stbs_pkg::stbs_status_t status_i,
  output stbs_pkg::stbs_cmd_t    cmd_o,
  output logic                   busy,
  output logic                   done_o
);
  import stbs_pkg::*;

  stbs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation_i == OpWrite) begin
            cmd_o.wr_en = 1'b1;
            cmd_o.clear = 1'b1;
            state_d     = ST_RESP;
          end else begin
            cmd_o.init = 1'b1;
            state_d    = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (status_i.n_zero) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d        = ST_RESP;
        end else if (!status_i.n_gt1) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_RESP;
        end else begin
          cmd_o.step = 1'b1;
          if (status_i.nxt_zero) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_RESP;
          end else begin
            cmd_o.use_nxt = 1'b1;
            cmd_o.rd_en   = 1'b1;
          end
        end
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
